// ===== hdl/sorted_task_queue_unit_macros.svh =====
// Assertion macros shared by the sorted task queue RTL.
// Depends on nothing; each user must have clock and reset in scope.
`ifndef SORTED_TASK_QUEUE_UNIT_MACROS_SVH
`define SORTED_TASK_QUEUE_UNIT_MACROS_SVH

// Checks that expr holds in the same cycle as cond.
`define STQ_ASSERT_NOW(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// Checks that expr holds in the cycle after cond.
`define STQ_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ===== hdl/stq_pkg.sv =====
// Package for the sorted task queue: sizes, the stored entry type, operation codes,
// controller states and the circular pointer step. Depends on nothing.
`default_nettype none

package stq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int ID_W        = 16;
   localparam int LEN_W       = 32;
   localparam int OP_W        = 2;
   localparam int COUNT_OUT_W = 7;

   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic [ID_W-1:0]  task_id;
      logic [LEN_W-1:0] duration;
   } entry_type;

   typedef enum logic [OP_W-1:0] {
      OP_TAIL    = 2'd0,
      OP_SORTED  = 2'd1,
      OP_DEQUEUE = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DEQ,
      ST_SCAN,
      ST_LAST
   } state_type;

   function automatic ptr_type next_ptr(input ptr_type ptr);
      ptr_type result;
      if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
         result = '0;
      end else begin
         result = ptr + PTR_W'(1);
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/sorted_task_queue_unit.sv =====
// Tail enqueue, sorted enqueue into an empty queue, full drop, empty dequeue and the unused
// code: result registered in the cycle after acceptance. Dequeue of a stored word: the word is
// read at acceptance, the result registered from ST_DEQ. Sorted enqueue with N stored entries,
// 0 < N < depth: scan in ST_SCAN, result registered from ST_LAST; one memory read per stored
// entry, and the insert ripples the later entries up one place during the same pass.
// One item in flight at a time. Synchronous reset empties the queue; memory is not cleared.
`default_nettype none

`include "sorted_task_queue_unit_macros.svh"

module sorted_task_queue_unit
   import stq_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [OP_W-1:0]        req_operation,
   input  wire logic [ID_W-1:0]        req_task_id,
   input  wire logic [LEN_W-1:0]       req_duration,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_out_valid,
   output logic [ID_W-1:0]             rsp_out_task_id,
   output logic [LEN_W-1:0]            rsp_out_duration,
   output logic                        rsp_was_empty,
   output logic                        rsp_dropped_full,
   output logic [COUNT_OUT_W-1:0]      rsp_entry_count
);

   // The queue is circular: head_ff is logical entry zero, tail_ff the next free slot.
   entry_type queue_mem [QUEUE_DEPTH];

   state_type state_ff, state_in;
   ptr_type   head_ff, head_in, tail_ff, tail_in, ptr_ff, ptr_in;
   cnt_type   count_ff, count_in, remain_ff, remain_in;
   logic      found_ff, found_in;
   entry_type carry_ff, carry_in, new_ff, new_in, rdata_ff;

   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_load;
   logic      rsp_ok_ff, rsp_ok_in, rsp_empty_ff, rsp_empty_in, rsp_drop_ff, rsp_drop_in;
   entry_type rsp_word_ff, rsp_word_in;
   cnt_type   rsp_count_ff, rsp_count_in;

   logic      mem_we, mem_re;
   ptr_type   mem_waddr, mem_raddr;
   entry_type mem_wdata;

   op_type    req_op;
   logic      accept, out_free, full, start_scan, start_deq, hit;

   assign req_op     = op_type'(req_operation);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept     = req_valid && !req_stall;
   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign start_scan = accept && (req_op == OP_SORTED) && !full && (count_ff != '0);
   assign start_deq  = accept && (req_op == OP_DEQUEUE) && (count_ff != '0);
   assign hit        = found_ff || (rdata_ff.duration > new_ff.duration);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_scan) begin
               state_in = ST_SCAN;
            end else if (start_deq) begin
               state_in = ST_DEQ;
            end
         end
         ST_DEQ: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (remain_ff == CNT_W'(1)) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      remain_in    = remain_ff;
      found_in     = found_ff;
      carry_in     = carry_ff;
      new_in       = new_ff;
      mem_we       = 1'b0;
      mem_waddr    = tail_ff;
      mem_wdata    = new_ff;
      mem_re       = 1'b0;
      mem_raddr    = head_ff;
      rsp_load     = 1'b0;
      rsp_ok_in    = 1'b0;
      rsp_empty_in = 1'b0;
      rsp_drop_in  = 1'b0;
      rsp_word_in  = '0;
      rsp_count_in = count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               new_in = '{task_id: req_task_id, duration: req_duration};
               unique case (req_op) inside
                  OP_TAIL, OP_SORTED: begin
                     if (full) begin
                        rsp_load    = 1'b1;
                        rsp_drop_in = 1'b1;
                     end else if ((req_op == OP_TAIL) || (count_ff == '0)) begin
                        mem_we       = 1'b1;
                        mem_wdata    = new_in;
                        tail_in      = next_ptr(tail_ff);
                        count_in     = count_ff + CNT_W'(1);
                        rsp_load     = 1'b1;
                        rsp_count_in = count_in;
                     end else begin
                        mem_re    = 1'b1;
                        ptr_in    = head_ff;
                        remain_in = count_ff;
                        found_in  = 1'b0;
                     end
                  end
                  OP_DEQUEUE: begin
                     if (count_ff == '0) begin
                        rsp_load     = 1'b1;
                        rsp_empty_in = 1'b1;
                     end else begin
                        mem_re = 1'b1;
                     end
                  end
                  OP_NONE: begin
                     rsp_load = 1'b1;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_DEQ: begin
            if (out_free) begin
               head_in      = next_ptr(head_ff);
               count_in     = count_ff - CNT_W'(1);
               rsp_load     = 1'b1;
               rsp_ok_in    = 1'b1;
               rsp_word_in  = rdata_ff;
               rsp_count_in = count_in;
            end
         end
         ST_SCAN: begin
            // Once the insert point is passed, every word moves up one slot.
            if (hit) begin
               mem_we    = 1'b1;
               mem_waddr = ptr_ff;
               mem_wdata = found_ff ? carry_ff : new_ff;
               carry_in  = rdata_ff;
               found_in  = 1'b1;
            end
            remain_in = remain_ff - CNT_W'(1);
            if (remain_ff != CNT_W'(1)) begin
               mem_re    = 1'b1;
               mem_raddr = next_ptr(ptr_ff);
               ptr_in    = next_ptr(ptr_ff);
            end
         end
         ST_LAST: begin
            if (out_free) begin
               mem_we       = 1'b1;
               mem_waddr    = tail_ff;
               mem_wdata    = found_ff ? carry_ff : new_ff;
               tail_in      = next_ptr(tail_ff);
               count_in     = count_ff + CNT_W'(1);
               rsp_load     = 1'b1;
               rsp_count_in = count_in;
            end
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      remain_ff <= remain_in;
      found_ff  <= found_in;
      carry_ff  <= carry_in;
      new_ff    <= new_in;
      if (rsp_load) begin
         rsp_ok_ff    <= rsp_ok_in;
         rsp_empty_ff <= rsp_empty_in;
         rsp_drop_ff  <= rsp_drop_in;
         rsp_word_ff  <= rsp_word_in;
         rsp_count_ff <= rsp_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         queue_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= queue_mem[mem_raddr];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_valid       = rsp_ok_ff;
   assign rsp_out_task_id     = rsp_word_ff.task_id;
   assign rsp_out_duration    = rsp_word_ff.duration;
   assign rsp_was_empty       = rsp_empty_ff;
   assign rsp_dropped_full    = rsp_drop_ff;
   assign rsp_entry_count     = COUNT_OUT_W'(rsp_count_ff);

   `STQ_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH), "Count exceeds depth.")
   `STQ_ASSERT_NOW(a_scan_range, state_ff == ST_SCAN,
      (count_ff != '0) && !full && (remain_ff != '0), "Scan with bad count.")
   `STQ_ASSERT_NOW(a_no_collide, mem_we && mem_re,
      mem_waddr != mem_raddr, "Read and write hit one entry.")
   `STQ_ASSERT_NEXT(a_insert_grows, (state_ff == ST_LAST) && out_free,
      count_ff == $past(count_ff) + CNT_W'(1), "Sorted insert lost count.")
   `STQ_ASSERT_NEXT(a_rsp_source, !rsp_valid_ff && !accept && (state_ff == ST_IDLE),
      !rsp_valid_ff, "Word appeared without a source.")

endmodule

`default_nettype wire

// ===== tb/tb_sorted_task_queue_unit.sv =====
// Self-checking testbench for sorted_task_queue_unit: tail, sorted, dequeue and unused-code
// words with random gaps and stalls, checked against a shadow queue kept in a small class.
// Depends on stq_pkg and the sorted_task_queue_unit RTL only.
module tb_sorted_task_queue_unit
   import stq_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 2000;
   localparam int ITEM_TARGET = 1050;
   localparam int SETTLE_CYCLES = QUEUE_DEPTH + 16;

   typedef struct packed {
      logic                   out_valid;
      logic [ID_W-1:0]        task_id;
      logic [LEN_W-1:0]       duration;
      logic                   was_empty;
      logic                   dropped_full;
      logic [COUNT_OUT_W-1:0] entry_count;
   } task_response_type;

   class task_queue_shadow;
      entry_type         stored[$];
      task_response_type awaited_words[$];
      int                errors;
      int                op_seen[4];
      int                drops;
      int                empties;
      int                deepest;

      function int depth();
         return stored.size();
      endfunction

      function int awaited();
         return awaited_words.size();
      endfunction

      function void note_request(op_type op, logic [ID_W-1:0] id, logic [LEN_W-1:0] len);
         task_response_type word;
         entry_type         item;
         int                pos;
         word = '0;
         item.task_id = id;
         item.duration = len;
         op_seen[int'(op)]++;
         case (op)
            OP_TAIL, OP_SORTED: begin
               if (stored.size() >= QUEUE_DEPTH) begin
                  word.dropped_full = 1'b1;
                  drops++;
               end else if (op == OP_TAIL) begin
                  stored.push_back(item);
               end else begin
                  pos = 0;
                  while (pos < stored.size() && stored[pos].duration <= len) pos++;
                  stored.insert(pos, item);
               end
            end
            OP_DEQUEUE: begin
               if (stored.size() == 0) begin
                  word.was_empty = 1'b1;
                  empties++;
               end else begin
                  item = stored.pop_front();
                  word.out_valid = 1'b1;
                  word.task_id = item.task_id;
                  word.duration = item.duration;
               end
            end
            default: begin
            end
         endcase
         word.entry_count = COUNT_OUT_W'(stored.size());
         if (stored.size() > deepest) deepest = stored.size();
         awaited_words.push_back(word);
      endfunction

      function void compare_field(string field, logic [LEN_W-1:0] want, logic [LEN_W-1:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            errors++;
         end
      endfunction

      function void check_response(task_response_type got);
         task_response_type want;
         if (awaited_words.size() == 0) begin
            $error("Response word with no request pending, entry_count %0d", got.entry_count);
            errors++;
            return;
         end
         want = awaited_words.pop_front();
         compare_field("out_valid", LEN_W'(want.out_valid), LEN_W'(got.out_valid));
         compare_field("out_task_id", LEN_W'(want.task_id), LEN_W'(got.task_id));
         compare_field("out_duration", want.duration, got.duration);
         compare_field("was_empty", LEN_W'(want.was_empty), LEN_W'(got.was_empty));
         compare_field("dropped_full", LEN_W'(want.dropped_full), LEN_W'(got.dropped_full));
         compare_field("entry_count", LEN_W'(want.entry_count), LEN_W'(got.entry_count));
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [OP_W-1:0]  req_operation = '0;
   logic [ID_W-1:0]  req_task_id = '0;
   logic [LEN_W-1:0] req_duration = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic             rsp_out_valid;
   logic [ID_W-1:0]  rsp_out_task_id;
   logic [LEN_W-1:0] rsp_out_duration;
   logic             rsp_was_empty;
   logic             rsp_dropped_full;
   logic [COUNT_OUT_W-1:0] rsp_entry_count;

   task_queue_shadow  board;
   task_response_type observed_word;
   bit                quiet_phase = 1'b0;
   int                items_sent = 0;
   int                idle_cycles = 0;

   sorted_task_queue_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_task_id        (req_task_id),
      .req_duration       (req_duration),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_valid      (rsp_out_valid),
      .rsp_out_task_id    (rsp_out_task_id),
      .rsp_out_duration   (rsp_out_duration),
      .rsp_was_empty      (rsp_was_empty),
      .rsp_dropped_full   (rsp_dropped_full),
      .rsp_entry_count    (rsp_entry_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   assign observed_word = {rsp_out_valid, rsp_out_task_id, rsp_out_duration,
                           rsp_was_empty, rsp_dropped_full, rsp_entry_count};

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_response(observed_word);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin : response_stalls
      int hold;
      wait (!reset);
      forever begin
         hold = quiet_phase ? 0 : $urandom_range(15);
         @(negedge clock);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   task automatic send_request(op_type op, logic [ID_W-1:0] id, logic [LEN_W-1:0] len);
      int gap;
      gap = quiet_phase ? 0 : $urandom_range(15);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_task_id <= id;
      req_duration <= len;
      do @(posedge clock); while (req_stall);
      board.note_request(op, id, len);
      items_sent++;
   endtask

   task automatic wait_for_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.awaited() != 0) @(posedge clock);
   endtask

   function automatic logic [LEN_W-1:0] pick_length();
      case ($urandom_range(3))
         0: return $urandom();
         1: return LEN_W'($urandom_range(7));
         2: return {29'h1FFF_FFFF, 3'($urandom_range(7))};
         default: return LEN_W'($urandom_range(255));
      endcase
   endfunction

   task automatic send_random_enqueue();
      send_request($urandom_range(1) ? OP_SORTED : OP_TAIL, ID_W'($urandom()), pick_length());
   endtask

   initial begin : stimulus
      int    phase;
      int    enqueue_share;
      int    roll;
      board = new();
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Directed: empty dequeue, unused code, field extremes, ties and sorted placement.
      send_request(OP_DEQUEUE, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(OP_NONE, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(OP_TAIL, 16'h0000, 32'h0000_0000);
      send_request(OP_TAIL, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(OP_SORTED, 16'h0001, 32'd100);
      send_request(OP_SORTED, 16'h0002, 32'd100);
      send_request(OP_SORTED, 16'h0003, 32'h0000_0000);
      send_request(OP_SORTED, 16'h0004, 32'hFFFF_FFFF);
      send_request(OP_SORTED, 16'h0005, 32'd50);
      send_request(OP_NONE, 16'h5A5A, 32'hA5A5_A5A5);
      repeat (8) send_request(OP_DEQUEUE, 16'h0000, 32'h0000_0000);
      send_request(OP_SORTED, 16'hAAAA, 32'h5555_5555);
      send_request(OP_DEQUEUE, 16'h5555, 32'hAAAA_AAAA);
      wait_for_responses();

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         quiet_phase = ($urandom_range(3) == 0);
         roll = (phase == 0) ? 5 : (phase == 1) ? 7 : $urandom_range(9);
         if (roll <= 4) begin
            enqueue_share = $urandom_range(40, 70);
            repeat (30) begin
               roll = $urandom_range(99);
               if (roll < 2) begin
                  send_request(OP_NONE, ID_W'($urandom()), LEN_W'($urandom()));
               end else if (roll < enqueue_share) begin
                  send_random_enqueue();
               end else begin
                  send_request(OP_DEQUEUE, ID_W'($urandom()), LEN_W'($urandom()));
               end
            end
         end else if (roll <= 6) begin
            while (board.depth() < QUEUE_DEPTH) send_random_enqueue();
            repeat (3) send_random_enqueue();
         end else if (roll <= 8) begin
            while (board.depth() > 0) send_request(OP_DEQUEUE, ID_W'($urandom()), pick_length());
            repeat (2) send_request(OP_DEQUEUE, ID_W'($urandom()), pick_length());
         end else begin
            wait_for_responses();
         end
         phase++;
      end

      quiet_phase = 1'b0;
      wait_for_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d words: %0d tail, %0d sorted, %0d dequeue, %0d with the unused code.",
               items_sent, board.op_seen[OP_TAIL], board.op_seen[OP_SORTED],
               board.op_seen[OP_DEQUEUE], board.op_seen[OP_NONE]);
      $display("Saw %0d full drops, %0d empty dequeues, and a deepest queue of %0d entries.",
               board.drops, board.empties, board.deepest);
      if (board.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
